>>> rtl/core/rk4_pkg.sv
// Shared constants, types and helper functions for the RK4 oscillator stepper.
package rk4_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS  = 28;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 48;
    localparam int STEP_W     = 29;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME  = 1'd1;

    localparam logic [STEP_W-1:0] STEP_RST = 29'd2684355;
    localparam logic [TIME_W-1:0] END_RST  = '1;

    // Shared multiplier: state operand (negated for position operands) times the step size.
    localparam int OPD_W  = POS_W + 1;
    localparam int MULB_W = STEP_W + 1;
    localparam int PROD_W = OPD_W + MULB_W;
    localparam int PH_W   = PROD_W - FRAC_BITS;
    localparam int HF_W   = PH_W - 1;
    localparam int STG_W  = PH_W + 1;

    // Division of the weighted slope sum by six, one ten-bit digit per cycle.
    localparam int DIG_W    = 10;
    localparam int ACCMIN_W = PH_W + 4;
    localparam int NDIG     = (ACCMIN_W + DIG_W - 1) / DIG_W;
    localparam int DIV_W    = NDIG * DIG_W;
    localparam int FIN_W    = DIV_W + 2;
    localparam int REM_W    = 3;
    localparam int DVAL_W   = REM_W + DIG_W;
    localparam int RECIP_W  = 14;
    localparam int RECIP_SH = 16;
    localparam logic [RECIP_W-1:0] RECIP6 = 14'd10923;

    // The sum is biased by six times QOFS so that it never goes negative;
    // the quotient then carries an offset of QOFS.
    localparam logic [DIV_W-1:0] QOFS     = DIV_W'(1) << (PH_W + 1);
    localparam logic [DIV_W-1:0] ACC_INIT = (QOFS << 2) + (QOFS << 1) + DIV_W'(3);

    // Multiply schedule.
    localparam int MUL_N  = 8;
    localparam int MIDX_W = $clog2(MUL_N);
    localparam int CNT_W  = $clog2(MUL_N + 1);

    // Multiplier operand codes.
    localparam logic [1:0] OP_NEG_X  = 2'd0;
    localparam logic [1:0] OP_V      = 2'd1;
    localparam logic [1:0] OP_VS     = 2'd2;
    localparam logic [1:0] OP_NEG_XS = 2'd3;

    // Stage-state update codes.
    localparam logic [1:0] UPD_NONE = 2'd0;
    localparam logic [1:0] UPD_HALF = 2'd1;
    localparam logic [1:0] UPD_FULL = 2'd2;

    typedef struct packed {
        logic       chan_v;
        logic       dbl;
        logic [1:0] upd;
    } t_post_ctl;

    typedef struct packed {
        logic                     req_type;
        logic signed [POS_W-1:0]  init_position;
        logic signed [POS_W-1:0]  init_velocity;
        logic        [TIME_W-1:0] start_time;
    } t_req_beat;

    typedef struct packed {
        logic        [TIME_W-1:0] time_out;
        logic signed [POS_W-1:0]  position_out;
        logic signed [POS_W-1:0]  velocity_out;
        logic                     past_end;
        logic                     saturated;
    } t_rsp_beat;

    typedef struct packed {
        logic              start;
        logic              mul_en;
        logic [MIDX_W-1:0] mul_idx;
        logic              post_en;
        logic [MIDX_W-1:0] post_idx;
        logic              div_en;
        logic              wb_en;
        logic              wb_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic past_now;
    } t_dp_sts;

    // Operand of each multiply; order is chosen so every stage value is
    // ready in the cycle after its slope has been rounded.
    function automatic logic [1:0] mul_op(input logic [MIDX_W-1:0] idx);
        logic [1:0] op;
        case (idx)
            3'd0:    op = OP_NEG_X;
            3'd1:    op = OP_V;
            3'd2:    op = OP_VS;
            3'd3:    op = OP_NEG_XS;
            3'd4:    op = OP_NEG_XS;
            3'd5:    op = OP_VS;
            3'd6:    op = OP_VS;
            3'd7:    op = OP_NEG_XS;
            default: op = OP_NEG_X;
        endcase
        return op;
    endfunction

    // What to do with the product of each multiply: which channel, the
    // weight in the final sum, and how the stage state is updated.
    function automatic t_post_ctl post_ctl(input logic [MIDX_W-1:0] idx);
        t_post_ctl pc;
        case (idx)
            3'd0:    pc = '{chan_v: 1'b1, dbl: 1'b0, upd: UPD_HALF};
            3'd1:    pc = '{chan_v: 1'b0, dbl: 1'b0, upd: UPD_HALF};
            3'd2:    pc = '{chan_v: 1'b0, dbl: 1'b1, upd: UPD_HALF};
            3'd3:    pc = '{chan_v: 1'b1, dbl: 1'b1, upd: UPD_HALF};
            3'd4:    pc = '{chan_v: 1'b1, dbl: 1'b1, upd: UPD_FULL};
            3'd5:    pc = '{chan_v: 1'b0, dbl: 1'b1, upd: UPD_FULL};
            3'd6:    pc = '{chan_v: 1'b0, dbl: 1'b0, upd: UPD_NONE};
            3'd7:    pc = '{chan_v: 1'b1, dbl: 1'b0, upd: UPD_NONE};
            default: pc = '{chan_v: 1'b0, dbl: 1'b0, upd: UPD_NONE};
        endcase
        return pc;
    endfunction

    // Saturate a signed value to the position width; the top bit is the flag.
    function automatic logic [POS_W:0] sat_pos(input logic [FIN_W-1:0] v);
        logic [FIN_W-POS_W:0] top;
        logic [POS_W:0]       res;
        top = v[FIN_W-1:POS_W-1];
        if ((&top) || !(|top)) begin
            res = {1'b0, v[POS_W-1:0]};
        end else if (v[FIN_W-1]) begin
            res = {1'b1, 1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(POS_W-1){1'b1}}};
        end
        return res;
    endfunction

    // One radix-1024 digit of division by six: returns {remainder, digit}.
    // The reciprocal product is exact for every value below 6 * 1024.
    function automatic logic [REM_W+DIG_W-1:0] div6_digit(
        input logic [REM_W-1:0] rem,
        input logic [DIG_W-1:0] dig
    );
        logic [DVAL_W-1:0]         val;
        logic [DVAL_W+RECIP_W-1:0] pr;
        logic [DIG_W-1:0]          q;
        logic [DVAL_W-1:0]         rr;
        val = {rem, dig};
        pr  = val * RECIP6;
        q   = pr[RECIP_SH+DIG_W-1:RECIP_SH];
        rr  = val - ({{REM_W{1'b0}}, q} << 2) - ({{REM_W{1'b0}}, q} << 1);
        return {rr[REM_W-1:0], q};
    endfunction

endpackage

>>> rtl/core/rk4_req_if.sv
// Request channel: valid/ready handshake carrying one load or step beat.
interface rk4_req_if import rk4_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [POS_W-1:0]  init_position;
    logic signed [POS_W-1:0]  init_velocity;
    logic        [TIME_W-1:0] start_time;

    modport source (
        output valid, req_type, init_position, init_velocity, start_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, init_position, init_velocity, start_time,
        output ready
    );
endinterface

>>> rtl/core/rk4_rsp_if.sv
// Response channel: valid/ready handshake carrying one result beat.
interface rk4_rsp_if import rk4_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic        [TIME_W-1:0] time_out;
    logic signed [POS_W-1:0]  position_out;
    logic signed [POS_W-1:0]  velocity_out;
    logic                     past_end;
    logic                     saturated;

    modport source (
        output valid, time_out, position_out, velocity_out, past_end, saturated,
        input  ready
    );
    modport sink (
        input  valid, time_out, position_out, velocity_out, past_end, saturated,
        output ready
    );
endinterface

>>> rtl/core/rk4_dp.sv
// Datapath: state, configuration, shared multiplier, slope sums, divide by six.
module rk4_dp import rk4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req_beat             i_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp_beat             o_rsp
);

    logic [STEP_W-1:0]        r_step;
    logic [TIME_W-1:0]        r_end;
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         r_vel;
    logic [TIME_W-1:0]        r_time;
    logic [POS_W-1:0]         r_xs;
    logic [POS_W-1:0]         r_vs;
    logic signed [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]         r_accx;
    logic [DIV_W-1:0]         r_accv;
    logic [REM_W-1:0]         r_remx;
    logic [REM_W-1:0]         r_remv;
    logic [DIV_W-1:0]         r_quox;
    logic [DIV_W-1:0]         r_quov;
    logic                     r_past;
    logic                     r_sat;
    logic                     r_out_valid;
    t_rsp_beat                r_out;

    logic [OPD_W-1:0]         opd;
    logic signed [PROD_W-1:0] n_prod;
    t_post_ctl                pc;
    logic [PH_W-1:0]          ph;
    logic [HF_W-1:0]          hf;
    logic                     rnd_bit;
    logic                     half_bit;
    logic [STG_W-1:0]         addend;
    logic                     cin;
    logic [POS_W-1:0]         base;
    logic [STG_W-1:0]         stg_sum;
    logic [POS_W:0]           stg_sat;
    logic [DIV_W-1:0]         acc_term;
    logic [DIV_W-1:0]         acc_cin;
    logic [DIV_W-1:0]         acc_sel;
    logic [DIV_W-1:0]         n_acc;
    logic [REM_W+DIG_W-1:0]   dstep_x;
    logic [REM_W+DIG_W-1:0]   dstep_v;
    logic [FIN_W-1:0]         fin_x;
    logic [FIN_W-1:0]         fin_v;
    logic [POS_W:0]           sat_x;
    logic [POS_W:0]           sat_v;
    logic [TIME_W:0]          t_sum;
    logic                     t_sat;
    logic [TIME_W-1:0]        t_new;
    logic                     past_now;

    assign past_now = r_time > r_end;

    // Multiplier operand select and product.
    always_comb begin
        case (mul_op(i_cmd.mul_idx))
            OP_NEG_X:  opd = OPD_W'(0) - {r_pos[POS_W-1], r_pos};
            OP_V:      opd = {r_vel[POS_W-1], r_vel};
            OP_VS:     opd = {r_vs[POS_W-1], r_vs};
            OP_NEG_XS: opd = OPD_W'(0) - {r_xs[POS_W-1], r_xs};
            default:   opd = '0;
        endcase
    end

    assign n_prod = $signed(opd) * $signed({1'b0, r_step});

    // Rounding of the registered product folds into carry-ins: the slope is
    // the shifted product plus the bit below the point, and half the slope
    // is the product shifted one further plus the OR of the two bits below.
    always_comb begin
        pc       = post_ctl(i_cmd.post_idx);
        ph       = r_prod[PROD_W-1:FRAC_BITS];
        hf       = r_prod[PROD_W-1:FRAC_BITS+1];
        rnd_bit  = r_prod[FRAC_BITS-1];
        half_bit = r_prod[FRAC_BITS] | r_prod[FRAC_BITS-1];
        base     = pc.chan_v ? r_vel : r_pos;
        if (pc.upd == UPD_FULL) begin
            addend = {{(STG_W-PH_W){ph[PH_W-1]}}, ph};
            cin    = rnd_bit;
        end else begin
            addend = {{(STG_W-HF_W){hf[HF_W-1]}}, hf};
            cin    = half_bit;
        end
        stg_sum  = {{(STG_W-POS_W){base[POS_W-1]}}, base} + addend
                   + {{(STG_W-1){1'b0}}, cin};
        stg_sat  = sat_pos({{(FIN_W-STG_W){stg_sum[STG_W-1]}}, stg_sum});
        acc_term = {{(DIV_W-PH_W){ph[PH_W-1]}}, ph} << pc.dbl;
        acc_cin  = {{(DIV_W-1){1'b0}}, rnd_bit} << pc.dbl;
        acc_sel  = pc.chan_v ? r_accv : r_accx;
        n_acc    = acc_sel + acc_term + acc_cin;
    end

    assign dstep_x = div6_digit(r_remx, r_accx[DIV_W-1 -: DIG_W]);
    assign dstep_v = div6_digit(r_remv, r_accv[DIV_W-1 -: DIG_W]);

    // Write-back values: state plus quotient minus its offset, and time.
    assign fin_x = {{(FIN_W-POS_W){r_pos[POS_W-1]}}, r_pos} + {2'b00, r_quox}
                   - {2'b00, QOFS};
    assign fin_v = {{(FIN_W-POS_W){r_vel[POS_W-1]}}, r_vel} + {2'b00, r_quov}
                   - {2'b00, QOFS};
    assign sat_x = sat_pos(fin_x);
    assign sat_v = sat_pos(fin_v);
    assign t_sum = {1'b0, r_time} + {{(TIME_W+1-STEP_W){1'b0}}, r_step};
    assign t_sat = t_sum[TIME_W];
    assign t_new = t_sat ? '1 : t_sum[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RST;
            r_end       <= END_RST;
            r_pos       <= '0;
            r_vel       <= '0;
            r_time      <= '0;
            r_past      <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_SIZE: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_END_TIME:  r_end  <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_past <= i_req.req_type & past_now;
                r_sat  <= 1'b0;
                if (!i_req.req_type) begin
                    r_pos  <= i_req.init_position;
                    r_vel  <= i_req.init_velocity;
                    r_time <= i_req.start_time;
                end
            end
            if (i_cmd.post_en && pc.upd != UPD_NONE && stg_sat[POS_W]) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.wb_en && i_cmd.wb_adv) begin
                r_pos  <= sat_x[POS_W-1:0];
                r_vel  <= sat_v[POS_W-1:0];
                r_time <= t_new;
            end
            if (i_cmd.wb_en) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.start) begin
            r_accx <= ACC_INIT;
            r_accv <= ACC_INIT;
            r_remx <= '0;
            r_remv <= '0;
        end else if (i_cmd.post_en) begin
            if (pc.chan_v) begin
                r_accv <= n_acc;
                if (pc.upd != UPD_NONE) begin
                    r_vs <= stg_sat[POS_W-1:0];
                end
            end else begin
                r_accx <= n_acc;
                if (pc.upd != UPD_NONE) begin
                    r_xs <= stg_sat[POS_W-1:0];
                end
            end
        end else if (i_cmd.div_en) begin
            r_accx <= {r_accx[DIV_W-DIG_W-1:0], {DIG_W{1'b0}}};
            r_accv <= {r_accv[DIV_W-DIG_W-1:0], {DIG_W{1'b0}}};
            r_remx <= dstep_x[REM_W+DIG_W-1:DIG_W];
            r_remv <= dstep_v[REM_W+DIG_W-1:DIG_W];
            r_quox <= {r_quox[DIV_W-DIG_W-1:0], dstep_x[DIG_W-1:0]};
            r_quov <= {r_quov[DIV_W-DIG_W-1:0], dstep_v[DIG_W-1:0]};
        end
        if (i_cmd.wb_en) begin
            r_out.time_out     <= r_time;
            r_out.position_out <= r_pos;
            r_out.velocity_out <= r_vel;
            r_out.past_end     <= r_past;
            r_out.saturated    <= i_cmd.wb_adv
                                  & (r_sat | sat_x[POS_W] | sat_v[POS_W] | t_sat);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_sts.past_now = past_now;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_out;

    a_wb_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb_en |-> (!r_out_valid || i_rsp_ready))
        else $error("result written over one not yet taken");

    a_time_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wb_en && i_cmd.wb_adv && !t_sat)
            |=> (r_time == $past(r_time) + TIME_W'($past(r_step))))
        else $error("time did not advance by the step size");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && !i_req.req_type)
            |=> (r_pos == $past(i_req.init_position)
                 && r_vel == $past(i_req.init_velocity)))
        else $error("load did not set position and velocity");

endmodule

>>> rtl/core/rk4_ctrl.sv
// Controller: sequences accept, multiplies, division digits and write-back.
module rk4_ctrl import rk4_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  logic    i_req_type,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_adv;
    logic             n_adv;
    logic [CNT_W-1:0] cnt_m1;
    logic             accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign cnt_m1      = r_cnt - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_adv   = r_adv;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (i_req_type && !i_sts.past_now) begin
                        n_state = ST_MUL;
                        n_cnt   = '0;
                        n_adv   = 1'b1;
                    end else begin
                        n_state = ST_WB;
                        n_adv   = 1'b0;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_en   = (r_cnt < CNT_W'(MUL_N));
                o_cmd.mul_idx  = r_cnt[MIDX_W-1:0];
                o_cmd.post_en  = (r_cnt != '0);
                o_cmd.post_idx = cnt_m1[MIDX_W-1:0];
                if (r_cnt == CNT_W'(MUL_N)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                if (r_cnt == CNT_W'(NDIG - 1)) begin
                    n_state = ST_WB;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_WB: begin
                o_cmd.wb_adv = r_adv;
                if (i_sts.out_free) begin
                    o_cmd.wb_en = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_adv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_adv   <= n_adv;
        end
    end

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type && !i_sts.past_now)
            |=> (r_state == ST_MUL && r_cnt == '0 && r_adv))
        else $error("advancing step did not start the multiply sequence");

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt == CNT_W'(MUL_N))
            |=> (r_state == ST_DIV && r_cnt == '0))
        else $error("multiply sequence did not hand over to division");

    a_div_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_W'(NDIG - 1)) |=> (r_state == ST_WB))
        else $error("division did not end after its last digit");

endmodule

>>> rtl/core/rk4_harmonic_oscillator_step.sv
// Top level of the fixed-point RK4 stepper for the harmonic oscillator.
//
// This block integrates x'' = -x with the classical fourth-order Runge-Kutta
// method. Position and velocity are signed Q4.28, time is unsigned Q20.28 and
// the step size is unsigned Q1.28 (29 bits). A request beat with req_type 0
// loads position, velocity and start time and echoes them back. A beat with
// req_type 1 reports the current time, position and velocity and, if time has
// not passed end_time, then advances one RK4 step and adds the step size to
// time; past that point it reports past_end and holds its state. Slopes round
// to nearest, state sums saturate to 32 bits and time saturates at its
// maximum, any clipping raising the saturated flag. A load beat, or a step
// beat past the end time, goes from accept straight to write-back. An
// advancing step goes through accept, then the eight slope products, which all
// go through a single shared 33 by 30 bit multiplier with a rounding and
// update stage behind it, then the division of the two weighted slope sums by
// six in four ten-bit digits, one digit per cycle, and last the write of the
// result and the new state. The multiplier and the chain of slopes that feed
// it set the step time. Results sit in an output register, so the next
// request beat is taken while a finished result beat still waits for the
// sink. Registers are written through a plain write port (index 0 is
// step_size, index 1 is end_time) and should only be written while the
// block is idle.
module rk4_harmonic_oscillator_step import rk4_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rk4_req_if.sink               i_req,
    rk4_rsp_if.source             o_rsp
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_req_beat req_beat;
    t_rsp_beat rsp_beat;
    logic      rsp_valid;

    // Gather the request fields into one beat for the datapath.
    assign req_beat.req_type      = i_req.req_type;
    assign req_beat.init_position = i_req.init_position;
    assign req_beat.init_velocity = i_req.init_velocity;
    assign req_beat.start_time    = i_req.start_time;

    rk4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req_type  (i_req.req_type),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rk4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_beat),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (rsp_beat)
    );

    // The result beat comes straight from the datapath's output register.
    assign o_rsp.valid        = rsp_valid;
    assign o_rsp.time_out     = rsp_beat.time_out;
    assign o_rsp.position_out = rsp_beat.position_out;
    assign o_rsp.velocity_out = rsp_beat.velocity_out;
    assign o_rsp.past_end     = rsp_beat.past_end;
    assign o_rsp.saturated    = rsp_beat.saturated;

endmodule
